>>> src/cegcf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph cycle finder package
// Shared sizes, operation and status codes for the cycle finder core.
// ----------------------------------------------------------------------------
package cegcf_pkg;
  localparam int MaxNodes  = 16;
  localparam int NodeBits  = 4;
  localparam int CountBits = 8;
  localparam int LenBits   = 5;
  localparam logic [CountBits-1:0] CountMax = '1;

  localparam logic [1:0] OpAdd    = 2'd0;
  localparam logic [1:0] OpRemove = 2'd1;
  localparam logic [1:0] OpFind   = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  localparam logic [2:0] StDone    = 3'd0;
  localparam logic [2:0] StRange   = 3'd1;
  localparam logic [2:0] StMissing = 3'd2;
  localparam logic [2:0] StSelf    = 3'd3;
  localparam logic [2:0] StNoCycle = 3'd4;
  localparam logic [2:0] StMember  = 3'd5;

  typedef struct packed {
    logic [NodeBits-1:0]  dest;
    logic [CountBits-1:0] count;
  } entry_t;
endpackage

>>> src/counted_edge_graph_cycle_finder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counted edge graph cycle finder
// Holds per-node ordered adjacency lists with repeat counts and searches for a
// cycle through a chosen node with an iterative depth-first walk.
// ----------------------------------------------------------------------------
// One transaction at a time is processed; s_tready is low while it runs. An
// add or remove scans the source list one entry at a time (address, then
// registered read data); a removal then shifts the tail down one entry at a
// time (S_UPD, S_SHIFT_R, S_SHIFT_W). A find reads one adjacency entry at a
// time from the single-port entry memory (S_FTOP, S_FRD, S_FCHK) and pops a
// frame in S_FTOP; the start node's entries are followed even into lists that
// were already walked. Each result is built in S_EMIT (after the first) and
// sent from S_RES, which waits out any m_tready stall. Results pass through
// one output register. tdata in: op[1:0], source[5:2], target[9:6]. tdata
// out: status[2:0], member[6:3]; tlast marks the final one.
module counted_edge_graph_cycle_finder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // op, source_node, target_node
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // status, member_node
  output logic        m_tlast    // last
);
  localparam int NB = cegcf_pkg::NodeBits;
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN = 4'd1, S_SCAN_W = 4'd2,
    S_SHIFT_R = 4'd3, S_SHIFT_W = 4'd4, S_RES = 4'd5, S_FTOP = 4'd6,
    S_FRD = 4'd7, S_FCHK = 4'd8, S_EMIT = 4'd9, S_UPD = 4'd10;

  logic [3:0] state;
  logic [4:0] node_count;
  logic [1:0] op;
  logic [NB-1:0] src, dst;
  logic [cegcf_pkg::LenBits-1:0] len [cegcf_pkg::MaxNodes];
  logic [cegcf_pkg::MaxNodes-1:0] visited;
  cegcf_pkg::entry_t mem [cegcf_pkg::MaxNodes*cegcf_pkg::MaxNodes];
  cegcf_pkg::entry_t rd;
  logic [2*NB-1:0] addr;
  logic wr_en;
  cegcf_pkg::entry_t wr_data;
  logic [NB-1:0] stk_node [cegcf_pkg::MaxNodes];
  logic [cegcf_pkg::LenBits-1:0] stk_slot [cegcf_pkg::MaxNodes];
  logic [cegcf_pkg::LenBits-1:0] depth, idx;
  logic [2:0] res_status;
  logic [NB-1:0] res_member;
  logic res_last;
  logic [4:0] emitted;

  logic [4:0] limit;
  assign limit = (node_count > 5'd16) ? 5'd16 : node_count;
  assign cfg_ready = (state == S_IDLE) && !m_tvalid;
  assign s_tready = (state == S_IDLE) && !m_tvalid;

  logic [NB-1:0] top_node;
  logic [cegcf_pkg::LenBits-1:0] top_slot;
  assign top_node = stk_node[depth[NB-1:0] - 1'b1];
  assign top_slot = stk_slot[depth[NB-1:0] - 1'b1];

  // The entry just read may be followed: not skipped as visited, list not empty.
  logic chk_open;
  assign chk_open = !(depth != 5'd1 && visited[rd.dest]) && (len[rd.dest] != 5'd0);

  always_ff @(posedge clk) begin
    if (wr_en) mem[addr] <= wr_data;
    rd <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      node_count <= 5'd16;
      m_tvalid <= 1'b0;
      for (int i = 0; i < cegcf_pkg::MaxNodes; i++) len[i] <= '0;
      visited <= '0;
      wr_en <= 1'b0;
    end else begin
      // S_SCAN and S_SHIFT_W are always entered with wr_en low and drive it
      // themselves.
      if (state != S_SCAN && state != S_SHIFT_W) wr_en <= 1'b0;
      if (m_tvalid && m_tready && state != S_RES) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) node_count <= cfg_data;
          if (s_tvalid && s_tready) begin
            op <= s_tdata[1:0];
            src <= s_tdata[5:2];
            dst <= s_tdata[9:6];
            idx <= '0;
            addr <= {s_tdata[5:2], {NB{1'b0}}};
            res_last <= 1'b1;
            res_member <= '0;
            if (s_tdata[1:0] == cegcf_pkg::OpFind) begin
              if ({1'b0, s_tdata[5:2]} >= limit) begin
                res_status <= cegcf_pkg::StRange;
                state <= S_RES;
              end else begin
                visited <= '0;
                stk_node[0] <= s_tdata[5:2];
                stk_slot[0] <= '0;
                depth <= 5'd1;
                state <= S_FTOP;
              end
            end else if (s_tdata[1:0] == cegcf_pkg::OpAdd ||
                         s_tdata[1:0] == cegcf_pkg::OpRemove) begin
              if (s_tdata[5:2] == s_tdata[9:6]) begin
                res_status <= cegcf_pkg::StSelf;
                state <= S_RES;
              end else if ({1'b0, s_tdata[5:2]} >= limit ||
                           {1'b0, s_tdata[9:6]} >= limit) begin
                res_status <= cegcf_pkg::StRange;
                state <= S_RES;
              end else begin
                res_status <= cegcf_pkg::StDone;
                state <= S_SCAN_W;
              end
            end else begin
              res_status <= cegcf_pkg::StDone;
              state <= S_RES;
            end
          end
        end
        // Read latency: address was set, data valid next cycle.
        S_SCAN_W: state <= S_SCAN;
        S_SCAN: begin
          if (idx >= len[src]) begin
            if (op == cegcf_pkg::OpRemove) res_status <= cegcf_pkg::StMissing;
            else if (len[src] < 5'd16) begin
              wr_en <= 1'b1;
              addr <= {src, idx[NB-1:0]};
              wr_data <= '{dest: dst, count: 8'd1};
              len[src] <= len[src] + 1'b1;
            end
            state <= S_RES;
          end else if (rd.dest == dst) begin
            if (op == cegcf_pkg::OpAdd) begin
              if (rd.count != cegcf_pkg::CountMax) begin
                wr_en <= 1'b1;
                wr_data <= '{dest: rd.dest, count: rd.count + 1'b1};
              end
              state <= S_RES;
            end else if (rd.count > 8'd1) begin
              wr_en <= 1'b1;
              wr_data <= '{dest: rd.dest, count: rd.count - 1'b1};
              state <= S_RES;
            end else state <= S_UPD;
          end else begin
            idx <= idx + 1'b1;
            addr <= {src, idx[NB-1:0] + 1'b1};
            state <= S_SCAN_W;
          end
        end
        // Deletion: copy entry idx+1 down to idx until the tail is reached.
        S_UPD: begin
          if (idx + 1'b1 >= len[src]) begin
            len[src] <= len[src] - 1'b1;
            state <= S_RES;
          end else begin
            addr <= {src, idx[NB-1:0] + 1'b1};
            state <= S_SHIFT_R;
          end
        end
        S_SHIFT_R: state <= S_SHIFT_W;
        S_SHIFT_W: begin
          wr_en <= 1'b1;
          wr_data <= rd;
          addr <= {src, idx[NB-1:0]};
          idx <= idx + 1'b1;
          state <= S_UPD;
        end
        S_FTOP: begin
          if (depth == 5'd0) begin
            res_status <= cegcf_pkg::StNoCycle;
            state <= S_RES;
          end else if (top_slot >= len[top_node]) begin
            depth <= depth - 1'b1;
          end else begin
            addr <= {top_node, top_slot[NB-1:0]};
            stk_slot[depth[NB-1:0] - 1'b1] <= top_slot + 1'b1;
            state <= S_FRD;
          end
        end
        S_FRD: state <= S_FCHK;
        S_FCHK: begin
          if (depth == 5'd1 || !visited[rd.dest]) visited[rd.dest] <= 1'b1;
          if (chk_open && rd.dest == src) begin
            res_status <= cegcf_pkg::StMember;
            res_member <= src;
            res_last <= (depth == 5'd1);
            emitted <= 5'd1;
            idx <= depth - 1'b1;
            state <= S_RES;
          end else begin
            if (chk_open && depth < 5'd16) begin
              stk_node[depth[NB-1:0]] <= rd.dest;
              stk_slot[depth[NB-1:0]] <= '0;
              depth <= depth + 1'b1;
            end
            state <= S_FTOP;
          end
        end
        S_RES: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata <= {1'b0, res_member, res_status};
            m_tlast <= res_last;
            state <= res_last ? S_IDLE : S_EMIT;
          end
        end
        S_EMIT: begin
          res_member <= stk_node[idx[NB-1:0]];
          res_last <= (idx == 5'd1) || (emitted == 5'd15);
          emitted <= emitted + 1'b1;
          idx <= idx - 1'b1;
          state <= S_RES;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !s_tready) else $error("ready while busy");
  a_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_FCHK) |-> (depth != 5'd0 && depth <= 5'd16))
    else $error("stack depth out of range");
  a_out: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid) else $error("result dropped");
`endif
endmodule
